/* hdl/csmc_pkg.sv */
package csmc_pkg;

  // Slice geometry: four 16-bit columns, each of four 4-bit nibbles.
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned NUM_NIBS = 4;
  localparam int unsigned COL_W    = NIB_W * NUM_NIBS;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned SLICE_W  = COL_W * NUM_COLS;
  localparam int unsigned FUNC_W   = 2;

  // Mixing mode codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FWD     = 2'd0,
    FUNC_INV     = 2'd1,
    FUNC_TRN     = 2'd2,
    FUNC_TRN_INV = 2'd3
  } func_t;

  typedef logic [NIB_W-1:0]   nib_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [SLICE_W-1:0] slice_t;

endpackage

/* hdl/csmc_if.sv */
// Input channel: mode and slice.
interface csmc_in_if;
  logic                     valid;
  logic                     ready;
  csmc_pkg::func_t          func;
  logic [csmc_pkg::SLICE_W-1:0] slice_in;

  modport source (output valid, output func, output slice_in, input ready);
  modport sink   (input valid, input func, input slice_in, output ready);
endinterface

// Result channel: mixed slice.
interface csmc_out_if;
  logic                     valid;
  logic                     ready;
  logic [csmc_pkg::SLICE_W-1:0] slice_out;

  modport source (output valid, output slice_out, input ready);
  modport sink   (input valid, input slice_out, output ready);
endinterface

/* hdl/csmc_column.sv */
module csmc_column (
  input  csmc_pkg::func_t func,
  input  csmc_pkg::col_t  col_in,
  output csmc_pkg::col_t  col_out
);

  // Multiplier alpha and its inverse, transpose and transposed inverse.
  function automatic csmc_pkg::nib_t alpha_f(input csmc_pkg::nib_t x);
    return {x[0] ^ x[1], x[3], x[2], x[1]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_i(input csmc_pkg::nib_t x);
    return {x[2], x[1], x[0], x[0] ^ x[3]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_t(input csmc_pkg::nib_t x);
    return {x[2], x[1], x[0] ^ x[3], x[3]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_ti(input csmc_pkg::nib_t x);
    return {x[0], x[3], x[2], x[0] ^ x[1]};
  endfunction

  // Fixed XOR and alpha network for the selected mode.
  always_comb begin
    csmc_pkg::nib_t a;
    csmc_pkg::nib_t b;
    csmc_pkg::nib_t c;
    csmc_pkg::nib_t d;
    a = col_in[3:0];
    b = col_in[7:4];
    c = col_in[11:8];
    d = col_in[15:12];
    unique case (func)
      csmc_pkg::FUNC_FWD: begin
        a = a ^ b; c = c ^ d;
        b = alpha_f(b); d = alpha_f(d);
        b = b ^ c; d = d ^ a;
        a = alpha_f(alpha_f(a)); c = alpha_f(alpha_f(c));
        a = a ^ b; c = c ^ d; b = b ^ c; d = d ^ a;
      end
      csmc_pkg::FUNC_INV: begin
        d = d ^ a; b = b ^ c; c = c ^ d; a = a ^ b;
        c = alpha_i(alpha_i(c)); a = alpha_i(alpha_i(a));
        d = d ^ a; b = b ^ c;
        d = alpha_i(d); b = alpha_i(b);
        c = c ^ d; a = a ^ b;
      end
      csmc_pkg::FUNC_TRN: begin
        a = a ^ d; c = c ^ b; d = d ^ c;
        c = alpha_t(alpha_t(c));
        c = c ^ b; b = b ^ a; c = c ^ a;
        a = alpha_t(alpha_t(a));
        b = alpha_t(b);
        a = a ^ d;
        d = alpha_t(d);
        b = b ^ a; d = d ^ c;
      end
      csmc_pkg::FUNC_TRN_INV: begin
        d = d ^ c; b = b ^ a;
        d = alpha_ti(d);
        a = a ^ d;
        b = alpha_ti(b);
        a = alpha_ti(alpha_ti(a));
        c = c ^ a; b = b ^ a; c = c ^ b;
        c = alpha_ti(alpha_ti(c));
        d = d ^ c; c = c ^ b; a = a ^ d;
      end
      default: begin
        a = '0; b = '0; c = '0; d = '0;
      end
    endcase
    col_out = {d, c, b, a};
  end

endmodule

/* hdl/cipher_slice_mix_columns.sv */
// Channel  Direction  Payload                    Handshake
// in_ch    sink       func (2), slice_in (64)    valid / ready
// out_ch   source     slice_out (64)             valid / ready
//
// A slice passes through two register stages: the input register, then the result register.
// One slice is taken every cycle while the result side keeps up; the column
// network between the two registers sets the cycle time.
// Reset (rst_n, synchronous, active low) empties both register stages.
// A stall on out_ch holds the result; in_ch stays ready while the input stage
// is empty or can move forward.
module cipher_slice_mix_columns (
  input logic               clk,
  input logic               rst_n,
  csmc_in_if.sink           in_ch,
  csmc_out_if.source        out_ch
);

  logic                     in_vld_r;
  csmc_pkg::func_t          func_r;
  csmc_pkg::slice_t         slice_in_r;
  logic                     out_vld_r;
  csmc_pkg::slice_t         slice_out_r;
  csmc_pkg::slice_t         slice_mix;
  logic                     out_adv;
  logic                     in_adv;

  // Each stage moves forward when the stage after it is empty or drained.
  assign out_adv     = !out_vld_r || out_ch.ready;
  assign in_adv      = !in_vld_r || out_adv;
  assign in_ch.ready = in_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_adv) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      func_r     <= in_ch.func;
      slice_in_r <= in_ch.slice_in;
    end
  end

  // One mixing network per column.
  for (genvar k = 0; k < csmc_pkg::NUM_COLS; k++) begin : g_col
    csmc_column u_col (
      .func    (func_r),
      .col_in  (slice_in_r[k*csmc_pkg::COL_W +: csmc_pkg::COL_W]),
      .col_out (slice_mix[k*csmc_pkg::COL_W +: csmc_pkg::COL_W])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld_r) begin
      slice_out_r <= slice_mix;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.slice_out = slice_out_r;

`ifndef SYNTHESIS
  // A loaded input stage that can move must show a result next cycle.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_adv) |=> out_ch.valid)
    else $error("input stage did not reach the result register");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled while result register empty");

  // A transfer into an empty pipeline passes the input register and then shows on the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !in_vld_r && !out_vld_r) |=> ##1 out_ch.valid)
    else $error("result missing two cycles after transfer");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 20;

  // One row of the directed table; a fixed result is used only where it is obvious.
  typedef struct {
    csmc_pkg::func_t  func;
    csmc_pkg::slice_t slice;
    logic             fixed;
    csmc_pkg::slice_t mixed;
  } dir_row_t;

  // A pending result, kept with its input for messages.
  typedef struct {
    csmc_pkg::func_t  func;
    csmc_pkg::slice_t slice;
    csmc_pkg::slice_t mixed;
  } pending_t;

  logic clk;
  logic rst_n;

  csmc_in_if  in_if ();
  csmc_out_if out_if ();

  cipher_slice_mix_columns i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  pending_t         mixed_q[$];
  int               n_mismatch;
  int               n_results;
  int               n_per_mode[4];
  int               cyc_count;
  logic             calm;
  logic             quiet;
  logic             hold_req;
  logic             fixed_on;
  csmc_pkg::slice_t fixed_val;

  // The mixing network is linear, so an all-zero slice stays zero in every mode.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{csmc_pkg::FUNC_FWD,     64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{csmc_pkg::FUNC_INV,     64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{csmc_pkg::FUNC_TRN,     64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{csmc_pkg::FUNC_TRN_INV, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000},
    '{csmc_pkg::FUNC_FWD,     64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_INV,     64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN,     64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN_INV, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_FWD,     64'h1000_0100_0010_0001, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_INV,     64'h1000_0100_0010_0001, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN,     64'h1000_0100_0010_0001, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN_INV, 64'h1000_0100_0010_0001, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_FWD,     64'h0008_0080_0800_8000, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_INV,     64'h0008_0080_0800_8000, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN,     64'h0008_0080_0800_8000, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN_INV, 64'h0008_0080_0800_8000, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_FWD,     64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_INV,     64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN,     64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{csmc_pkg::FUNC_TRN_INV, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0}
  };

  // Nibble multipliers, bit 0 of the nibble on the right.
  function automatic csmc_pkg::nib_t alpha_fwd(input csmc_pkg::nib_t x);
    return {x[0] ^ x[1], x[3], x[2], x[1]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_inv(input csmc_pkg::nib_t x);
    return {x[2], x[1], x[0], x[0] ^ x[3]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_trn(input csmc_pkg::nib_t x);
    return {x[2], x[1], x[0] ^ x[3], x[3]};
  endfunction

  function automatic csmc_pkg::nib_t alpha_trn_inv(input csmc_pkg::nib_t x);
    return {x[0], x[3], x[2], x[0] ^ x[1]};
  endfunction

  // Mixing of one column in the selected mode.
  function automatic csmc_pkg::col_t mix_column(input csmc_pkg::col_t col,
                                                input csmc_pkg::func_t f);
    csmc_pkg::nib_t a, b, c, d;
    a = col[3:0];
    b = col[7:4];
    c = col[11:8];
    d = col[15:12];
    case (f)
      csmc_pkg::FUNC_FWD: begin
        a ^= b; c ^= d;
        b = alpha_fwd(b); d = alpha_fwd(d);
        b ^= c; d ^= a;
        a = alpha_fwd(alpha_fwd(a)); c = alpha_fwd(alpha_fwd(c));
        a ^= b; c ^= d; b ^= c; d ^= a;
      end
      csmc_pkg::FUNC_INV: begin
        d ^= a; b ^= c; c ^= d; a ^= b;
        c = alpha_inv(alpha_inv(c)); a = alpha_inv(alpha_inv(a));
        d ^= a; b ^= c;
        d = alpha_inv(d); b = alpha_inv(b);
        c ^= d; a ^= b;
      end
      csmc_pkg::FUNC_TRN: begin
        a ^= d; c ^= b; d ^= c;
        c = alpha_trn(alpha_trn(c));
        c ^= b; b ^= a; c ^= a;
        a = alpha_trn(alpha_trn(a));
        b = alpha_trn(b);
        a ^= d;
        d = alpha_trn(d);
        b ^= a; d ^= c;
      end
      default: begin
        d ^= c; b ^= a;
        d = alpha_trn_inv(d);
        a ^= d;
        b = alpha_trn_inv(b);
        a = alpha_trn_inv(alpha_trn_inv(a));
        c ^= a; b ^= a; c ^= b;
        c = alpha_trn_inv(alpha_trn_inv(c));
        d ^= c; c ^= b; a ^= d;
      end
    endcase
    return {d, c, b, a};
  endfunction

  // Every column is mixed on its own.
  function automatic csmc_pkg::slice_t mix_slice(input csmc_pkg::slice_t s,
                                                 input csmc_pkg::func_t f);
    csmc_pkg::slice_t r;
    r = '0;
    for (int k = 0; k < csmc_pkg::NUM_COLS; k++) begin
      r[k*csmc_pkg::COL_W +: csmc_pkg::COL_W] =
        mix_column(s[k*csmc_pkg::COL_W +: csmc_pkg::COL_W], f);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input csmc_pkg::slice_t got,
                                 input csmc_pkg::slice_t want);
    $display("[%0d] ERROR %s: got %016h, want %016h", cyc_count, what, got, want);
    n_mismatch++;
  endtask

  // Offer one slice and hold it until the transfer happens.
  task automatic send_slice(input csmc_pkg::func_t f, input csmc_pkg::slice_t s,
                            input logic fixed, input csmc_pkg::slice_t want);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.func     <= f;
    in_if.slice_in <= s;
    fixed_on       <= fixed;
    fixed_val      <= want;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Wait with the input idle until every pending result has come out.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (mixed_q.size() != 0);
  endtask

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Cycle count, quiet windows for both sides, and the run limit.
  assign calm = (cyc_count[8:7] == 2'b11);

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Transfers on both channels: compare results, then record new inputs.
  always @(posedge clk) begin
    pending_t p;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (mixed_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_if.slice_out, '0);
        end else begin
          p = mixed_q.pop_front();
          if (out_if.slice_out !== p.mixed) begin
            report_mismatch($sformatf("slice_out, mode %s, slice %016h", p.func.name(),
                                      p.slice), out_if.slice_out, p.mixed);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        p.func  = in_if.func;
        p.slice = in_if.slice_in;
        p.mixed = fixed_on ? fixed_val : mix_slice(in_if.slice_in, in_if.func);
        mixed_q.push_back(p);
        n_per_mode[in_if.func]++;
      end
    end
  end

  // Stimulus: directed table, then random slices in several phases.
  initial begin
    csmc_pkg::func_t  f;
    csmc_pkg::slice_t s;
    int               pick;
    cyc_count      = 0;
    n_mismatch     = 0;
    n_results      = 0;
    n_per_mode     = '{0, 0, 0, 0};
    quiet          = 1'b0;
    hold_req       = 1'b0;
    fixed_on       = 1'b0;
    fixed_val      = '0;
    in_if.valid    = 1'b0;
    in_if.func     = csmc_pkg::FUNC_FWD;
    in_if.slice_in = '0;
    rst_n          = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_slice(dir_tab[i].func, dir_tab[i].slice, dir_tab[i].fixed, dir_tab[i].mixed);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        hold_req = 1'b1;
      end
      if (i == 400) begin
        drain_results();
      end
      if (i == 700) begin
        quiet = 1'b1;
      end
      f    = csmc_pkg::func_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      // Mostly dense slices, some sparse ones and some with repeated columns.
      if (pick < 7) begin
        s = {$urandom, $urandom};
      end else if (pick < 9) begin
        s = '0;
        s[$urandom_range(0, csmc_pkg::NUM_COLS * csmc_pkg::NUM_NIBS - 1) * csmc_pkg::NIB_W
          +: csmc_pkg::NIB_W] = csmc_pkg::nib_t'($urandom_range(1, 15));
      end else begin
        s = {csmc_pkg::NUM_COLS{csmc_pkg::col_t'($urandom_range(0, 16'hffff))}};
      end
      send_slice(f, s, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (mixed_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d slices (forward %0d, inverse %0d, transposed %0d, transposed inverse %0d).",
             n_per_mode[0] + n_per_mode[1] + n_per_mode[2] + n_per_mode[3],
             n_per_mode[csmc_pkg::FUNC_FWD], n_per_mode[csmc_pkg::FUNC_INV],
             n_per_mode[csmc_pkg::FUNC_TRN], n_per_mode[csmc_pkg::FUNC_TRN_INV]);
    $display("Checked %0d results under random stalls, a long output hold-off and a drain.",
             n_results);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* cipher_slice_mix_columns.f */
hdl/csmc_pkg.sv
hdl/csmc_if.sv
hdl/csmc_column.sv
hdl/cipher_slice_mix_columns.sv
sim/testbench.sv
